// ===== design/float_round_to_prec_and_min_exp_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the rounding pipeline
// Clocked on clk, disabled while arst_n is low.
// ------------------------------------------------------------------------
`ifndef FLOAT_ROUND_TO_PREC_AND_MIN_EXP_MACROS_SVH
`define FLOAT_ROUND_TO_PREC_AND_MIN_EXP_MACROS_SVH

// same-cycle implication
`define FRU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication
`define FRU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// ===== design/fru_pkg.sv =====
// ------------------------------------------------------------------------
// fru_pkg
// Shared constants and types of the rounding pipeline.
// ------------------------------------------------------------------------
package fru_pkg;

	localparam int SIG_WIDTH_DEF = 64;
	localparam int EXP_WIDTH_DEF = 16;
	localparam int PREC_WIDTH    = 7;

	localparam logic [1:0] DIR_ZERO = 2'd0;
	localparam logic [1:0] DIR_AWAY = 2'd1;
	localparam logic [1:0] DIR_EVEN = 2'd2;
	localparam logic [1:0] DIR_ODD  = 2'd3;

	typedef struct packed {
		logic half;
		logic sticky;
	} rnd_bits_t;

	typedef struct packed {
		logic       nearest;
		logic [1:0] dir;
	} rnd_rule_t;

endpackage

// ===== design/fru_bitlen.sv =====
// ------------------------------------------------------------------------
// fru_bitlen
// Bit length of the significand (index of top set bit plus one), by a
// binary search over halving windows.
// ------------------------------------------------------------------------
module fru_bitlen #(
	parameter int SIG_WIDTH = fru_pkg::SIG_WIDTH_DEF
) (
	input  logic [SIG_WIDTH-1:0]         sig,
	output logic [$clog2(SIG_WIDTH+1)-1:0] bw
);
	localparam int LG = $clog2(SIG_WIDTH);
	localparam int P2 = 1 << LG;
	localparam int BW = $clog2(SIG_WIDTH+1);

	logic [P2-1:0] v;
	logic [LG-1:0] pos;

	always_comb begin
		v   = P2'(sig);
		pos = '0;
		for (int l = LG-1; l >= 0; l--) begin
			if ((v >> (1 << l)) != '0) begin
				pos = pos | LG'(1 << l);
				v   = v >> (1 << l);
			end
		end
		bw = (sig == '0) ? '0 : BW'(pos) + BW'(1);
	end

endmodule

// ===== design/fru_split.sv =====
// ------------------------------------------------------------------------
// fru_split
// Splits the significand at the rounding position: kept part, half bit
// and sticky bit.
// ------------------------------------------------------------------------
module fru_split #(
	parameter int SIG_WIDTH = fru_pkg::SIG_WIDTH_DEF
) (
	input  logic [SIG_WIDTH-1:0]         sig,
	input  logic [$clog2(SIG_WIDTH)-1:0] shamt,
	input  logic                         big,
	output logic [SIG_WIDTH-1:0]         kept,
	output fru_pkg::rnd_bits_t           bits
);
	logic [SIG_WIDTH-1:0] low_mask;

	always_comb begin
		low_mask = ~({SIG_WIDTH{1'b1}} << shamt);
		if (big) begin
			// position above the top bit: everything is discarded
			kept        = '0;
			bits.half   = 1'b0;
			bits.sticky = |sig;
		end else begin
			kept        = (sig >> shamt) >> 1;
			bits.half   = sig[shamt];
			bits.sticky = |(sig & low_mask);
		end
	end

endmodule

// ===== design/fru_incr.sv =====
// ------------------------------------------------------------------------
// fru_incr
// Increment decision, increment and renormalization on precision carry.
// ------------------------------------------------------------------------
module fru_incr #(
	parameter int SIG_WIDTH = fru_pkg::SIG_WIDTH_DEF
) (
	input  logic [SIG_WIDTH-1:0]           kept,
	input  fru_pkg::rnd_bits_t             bits,
	input  fru_pkg::rnd_rule_t             rule,
	input  logic                           has_prec,
	input  logic [$clog2(SIG_WIDTH+1)-1:0] prec,
	output logic [SIG_WIDTH-1:0]           sig,
	output logic                           renorm,
	output logic                           inexact
);
	logic           dir_up;
	logic           up;
	logic [SIG_WIDTH:0] inc;

	always_comb begin
		case (rule.dir)
			fru_pkg::DIR_ZERO: dir_up = 1'b0;
			fru_pkg::DIR_AWAY: dir_up = 1'b1;
			fru_pkg::DIR_EVEN: dir_up = kept[0];
			fru_pkg::DIR_ODD:  dir_up = ~kept[0];
			default:           dir_up = 1'b0;
		endcase

		inexact = bits.half | bits.sticky;
		if (!inexact)
			up = 1'b0;
		else if (rule.nearest)
			up = bits.half & (bits.sticky | dir_up);
		else
			up = dir_up;

		inc = {1'b0, kept} + (SIG_WIDTH+1)'(up);
		// kept never exceeds prec bits, so a carry only lands exactly on bit prec
		renorm = has_prec & up & inc[prec];
		sig    = renorm ? inc[SIG_WIDTH:1] : inc[SIG_WIDTH-1:0];
	end

endmodule

// ===== design/float_round_to_prec_and_min_exp.sv =====
// ------------------------------------------------------------------------
// float_round_to_prec_and_min_exp
// Rounds a binary number to a maximum precision and/or minimum exponent.
// ------------------------------------------------------------------------
// Four-stage pipeline that takes one item every cycle; busy is always low.
// A result appears with done once the item has passed all stages (stage 1: bit
// length, stage 2: rounding position, stage 3: barrel shift and sticky
// reduction, stage 4: increment and renormalize). done lasts one cycle and
// the result must be taken then. With bad_request set, all other result
// fields read zero.
`include "float_round_to_prec_and_min_exp_macros.svh"

module float_round_to_prec_and_min_exp #(
	parameter int SIG_WIDTH = fru_pkg::SIG_WIDTH_DEF,
	parameter int EXP_WIDTH = fru_pkg::EXP_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            sign,
	input  logic signed [EXP_WIDTH-1:0]     exponent,
	input  logic [SIG_WIDTH-1:0]            significand,
	input  logic                            has_max_prec,
	input  logic [fru_pkg::PREC_WIDTH-1:0]  max_prec,
	input  logic                            has_min_exp,
	input  logic signed [EXP_WIDTH-1:0]     min_exp,
	input  logic                            round_nearest,
	input  logic [1:0]                      round_dir,
	output logic                            done,
	output logic                            out_sign,
	output logic signed [EXP_WIDTH:0]       out_exponent,
	output logic [SIG_WIDTH-1:0]            out_significand,
	output logic                            inexact,
	output logic                            bad_request
);
	localparam int PW  = fru_pkg::PREC_WIDTH;
	localparam int PIW = $clog2(SIG_WIDTH+1);
	localparam int SHW = $clog2(SIG_WIDTH);
	localparam int DW  = EXP_WIDTH + 2;
	localparam int OW  = EXP_WIDTH + 1;

	assign busy = 1'b0;

	// ---------------- stage 1: bit length, precision clamp
	logic             take;
	logic [PIW-1:0]   bw_c;
	logic [PIW-1:0]   prec_c;

	assign take = start & ~busy;

	fru_bitlen #(.SIG_WIDTH(SIG_WIDTH)) u_bitlen (
		.sig (significand),
		.bw  (bw_c)
	);

	always_comb begin
		if (max_prec == '0)
			prec_c = PIW'(1);
		else if (max_prec > PW'(SIG_WIDTH))
			prec_c = PIW'(SIG_WIDTH);
		else
			prec_c = max_prec[PIW-1:0];
	end

	logic                        valid_s1;
	logic                        sign_s1;
	logic signed [EXP_WIDTH-1:0] exp_s1;
	logic [SIG_WIDTH-1:0]        sig_s1;
	logic                        hp_s1;
	logic                        hm_s1;
	logic [PIW-1:0]              prec_s1;
	logic signed [EXP_WIDTH-1:0] mn_s1;
	fru_pkg::rnd_rule_t          rule_s1;
	logic [PIW-1:0]              bw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		sign_s1         <= sign;
		exp_s1          <= exponent;
		sig_s1          <= significand;
		hp_s1           <= has_max_prec;
		hm_s1           <= has_min_exp;
		prec_s1         <= prec_c;
		mn_s1           <= min_exp;
		rule_s1.nearest <= round_nearest;
		rule_s1.dir     <= round_dir;
		bw_s1           <= bw_c;
	end

	// ---------------- stage 2: distance from exponent to rounding position
	logic signed [DW-1:0] dp_c;
	logic signed [DW-1:0] dm_c;
	logic signed [DW-1:0] d_c;

	always_comb begin
		dp_c = DW'(bw_s1) - DW'(prec_s1) - DW'(1);
		dm_c = DW'(mn_s1) - DW'(exp_s1);
		if (hp_s1 && hm_s1)
			d_c = (dm_c > dp_c) ? dm_c : dp_c;
		else if (hp_s1)
			d_c = dp_c;
		else
			d_c = dm_c;
	end

	logic                        valid_s2;
	logic                        sign_s2;
	logic signed [EXP_WIDTH-1:0] exp_s2;
	logic [SIG_WIDTH-1:0]        sig_s2;
	logic                        hp_s2;
	logic                        bad_s2;
	logic                        zero_s2;
	logic [PIW-1:0]              prec_s2;
	fru_pkg::rnd_rule_t          rule_s2;
	logic signed [DW-1:0]        d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		exp_s2  <= exp_s1;
		sig_s2  <= sig_s1;
		hp_s2   <= hp_s1;
		bad_s2  <= ~hp_s1 & ~hm_s1;
		zero_s2 <= (bw_s1 == '0);
		prec_s2 <= prec_s1;
		rule_s2 <= rule_s1;
		d_s2    <= d_c;
	end

	// ---------------- stage 3: split at the rounding position
	logic                 neg_c;
	logic                 big_c;
	logic                 pass_c;
	logic [SIG_WIDTH-1:0] kept_c;
	fru_pkg::rnd_bits_t   bits_c;
	logic signed [OW-1:0] oe_c;
	logic signed [DW-1:0] n1_c;

	assign neg_c  = d_s2[DW-1];
	assign big_c  = ~neg_c & (d_s2 >= DW'(SIG_WIDTH));
	// position below all digits: value goes through unchanged
	assign pass_c = neg_c & ~zero_s2;

	fru_split #(.SIG_WIDTH(SIG_WIDTH)) u_split (
		.sig   (sig_s2),
		.shamt (d_s2[SHW-1:0]),
		.big   (big_c),
		.kept  (kept_c),
		.bits  (bits_c)
	);

	assign n1_c = DW'(exp_s2) + d_s2 + DW'(1);
	assign oe_c = pass_c ? OW'(exp_s2) : n1_c[OW-1:0];

	logic                 valid_s3;
	logic                 sign_s3;
	logic                 hp_s3;
	logic                 bad_s3;
	logic [PIW-1:0]       prec_s3;
	fru_pkg::rnd_rule_t   rule_s3;
	logic [SIG_WIDTH-1:0] kept_s3;
	fru_pkg::rnd_bits_t   bits_s3;
	logic signed [OW-1:0] oe_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		sign_s3 <= sign_s2;
		hp_s3   <= hp_s2;
		bad_s3  <= bad_s2;
		prec_s3 <= prec_s2;
		rule_s3 <= rule_s2;
		oe_s3   <= oe_c;
		if (pass_c || zero_s2) begin
			kept_s3 <= pass_c ? sig_s2 : '0;
			bits_s3 <= '0;
		end else begin
			kept_s3 <= kept_c;
			bits_s3 <= bits_c;
		end
	end

	// ---------------- stage 4: increment, renormalize, output register
	logic [SIG_WIDTH-1:0] rsig_c;
	logic                 renorm_c;
	logic                 inex_c;

	fru_incr #(.SIG_WIDTH(SIG_WIDTH)) u_incr (
		.kept     (kept_s3),
		.bits     (bits_s3),
		.rule     (rule_s3),
		.has_prec (hp_s3),
		.prec     (prec_s3),
		.sig      (rsig_c),
		.renorm   (renorm_c),
		.inexact  (inex_c)
	);

	logic                 valid_s4;
	logic                 sign_s4;
	logic signed [OW-1:0] oe_s4;
	logic [SIG_WIDTH-1:0] sig_s4;
	logic                 inex_s4;
	logic                 bad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else         valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		bad_s4 <= bad_s3;
		if (bad_s3) begin
			sign_s4 <= 1'b0;
			oe_s4   <= '0;
			sig_s4  <= '0;
			inex_s4 <= 1'b0;
		end else begin
			sign_s4 <= sign_s3;
			oe_s4   <= oe_s3 + OW'(renorm_c);
			sig_s4  <= rsig_c;
			inex_s4 <= inex_c;
		end
	end

	assign done            = valid_s4;
	assign out_sign        = sign_s4;
	assign out_exponent    = oe_s4;
	assign out_significand = sig_s4;
	assign inexact         = inex_s4;
	assign bad_request     = bad_s4;

	// ---------------- assertions
	`FRU_ASSERT_NXT(a_latency, start && !busy, ##3 done, "result missing four cycles after transfer")
	`FRU_ASSERT_IMP(a_bad_zero, done && bad_request,
		(out_significand == '0) && !inexact && (out_exponent == '0) && !out_sign,
		"bad request result carries nonzero fields")
	`FRU_ASSERT_NXT(a_no_spurious, !valid_s3, !done, "result strobe without an item in flight")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for float_round_to_prec_and_min_exp
// Sends rounding requests (directed corner cases, then shaped random ones)
// in bursts with random gaps, predicts each rounded value and checks every
// done strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1000;
	localparam int PW = fru_pkg::PREC_WIDTH;

	typedef struct {
		logic                  sgn;
		logic signed [15:0]    expo;
		logic [63:0]           sig;
		logic                  has_prec;
		logic [PW-1:0]         prec;
		logic                  has_min;
		logic signed [15:0]    min_pos;
		logic                  nearest;
		logic [1:0]            dir;
	} round_req_t;

	typedef struct {
		logic               sgn;
		logic signed [16:0] expo;
		logic [63:0]        sig;
		logic               inexact;
		logic               bad;
	} round_res_t;

	class round_checker;
		round_res_t pending_rounded[$];
		int mismatches = 0;

		function int bit_length(logic [63:0] v);
			for (int i = 63; i >= 0; i--)
				if (v[i])
					return i + 1;
			return 0;
		endfunction

		function logic dir_up(logic [1:0] dir, logic [63:0] kept);
			case (dir)
				fru_pkg::DIR_ZERO: return 1'b0;
				fru_pkg::DIR_AWAY: return 1'b1;
				fru_pkg::DIR_EVEN: return kept[0];
				default:           return ~kept[0];
			endcase
		endfunction

		function round_res_t round_value(round_req_t q);
			round_res_t r;
			int bw, p, pos, shift, oexp;
			logic [63:0] kept;
			logic half, sticky, up;
			r = '{sgn: 1'b0, expo: '0, sig: '0, inexact: 1'b0, bad: 1'b0};
			if (!q.has_prec && !q.has_min) begin
				r.bad = 1'b1;
				return r;
			end
			bw = bit_length(q.sig);
			p = int'(q.prec);
			if (p < 1)
				p = 1;
			if (p > 64)
				p = 64;
			if (q.has_prec) begin
				pos = int'(q.expo) + bw - 1 - p;
				if (q.has_min && int'(q.min_pos) > pos)
					pos = int'(q.min_pos);
			end else begin
				pos = int'(q.min_pos);
			end
			r.sgn = q.sgn;
			if (q.sig == '0) begin
				oexp = pos + 1;
				kept = '0;
			end else if (pos < int'(q.expo)) begin
				oexp = int'(q.expo);
				kept = q.sig;
			end else begin
				shift = pos - int'(q.expo);
				if (shift < 64) begin
					half = q.sig[shift];
					sticky = |(q.sig & ((64'd1 << shift) - 64'd1));
				end else begin
					half = 1'b0;
					sticky = 1'b1;
				end
				kept = (shift < 63) ? q.sig >> (shift + 1) : '0;
				oexp = pos + 1;
				if (half || sticky) begin
					r.inexact = 1'b1;
					// nearest: direction only breaks an exact tie
					if (q.nearest)
						up = half && (sticky || dir_up(q.dir, kept));
					else
						up = dir_up(q.dir, kept);
					if (up) begin
						kept = kept + 64'd1;
						if (q.has_prec && bit_length(kept) > p) begin
							kept = kept >> 1;
							oexp = oexp + 1;
						end
					end
				end
			end
			r.expo = oexp[16:0];
			r.sig = kept;
			return r;
		endfunction

		function void note_request(round_req_t q);
			pending_rounded.push_back(round_value(q));
		endfunction

		function int pending();
			return pending_rounded.size();
		endfunction

		function void check_rounded(round_res_t got);
			round_res_t want;
			logic bad;
			if (pending_rounded.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing outstanding: sign %0b exp %0d sig %0h",
					$time, got.sgn, got.expo, got.sig);
				return;
			end
			want = pending_rounded.pop_front();
			bad = (got.sgn !== want.sgn) || (got.expo !== want.expo) ||
				(got.sig !== want.sig) || (got.inexact !== want.inexact) ||
				(got.bad !== want.bad);
			if (!bad)
				return;
			mismatches++;
			if (got.sgn !== want.sgn)
				$display("%0t: out_sign expected %0b actual %0b", $time, want.sgn, got.sgn);
			if (got.expo !== want.expo)
				$display("%0t: out_exponent expected %0d actual %0d", $time,
					want.expo, got.expo);
			if (got.sig !== want.sig)
				$display("%0t: out_significand expected %h actual %h", $time,
					want.sig, got.sig);
			if (got.inexact !== want.inexact)
				$display("%0t: inexact expected %0b actual %0b", $time,
					want.inexact, got.inexact);
			if (got.bad !== want.bad)
				$display("%0t: bad_request expected %0b actual %0b", $time,
					want.bad, got.bad);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  sign = 1'b0;
	logic signed [15:0]    exponent = '0;
	logic [63:0]           significand = '0;
	logic                  has_max_prec = 1'b0;
	logic [PW-1:0]         max_prec = '0;
	logic                  has_min_exp = 1'b0;
	logic signed [15:0]    min_exp = '0;
	logic                  round_nearest = 1'b0;
	logic [1:0]            round_dir = fru_pkg::DIR_ZERO;
	logic                  done;
	logic                  out_sign;
	logic signed [16:0]    out_exponent;
	logic [63:0]           out_significand;
	logic                  inexact;
	logic                  bad_request;

	round_checker ledger = new();
	int idle_cycles = 0;
	int burst_left = 0;
	logic moved;

	float_round_to_prec_and_min_exp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sign(sign), .exponent(exponent), .significand(significand),
		.has_max_prec(has_max_prec), .max_prec(max_prec),
		.has_min_exp(has_min_exp), .min_exp(min_exp),
		.round_nearest(round_nearest), .round_dir(round_dir),
		.done(done), .out_sign(out_sign), .out_exponent(out_exponent),
		.out_significand(out_significand), .inexact(inexact),
		.bad_request(bad_request)
	);

	always #4 clk = ~clk;

	// transfers, result checks and the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (start && !busy) begin
				ledger.note_request('{sign, exponent, significand, has_max_prec, max_prec,
					has_min_exp, min_exp, round_nearest, round_dir});
				moved = 1'b1;
			end
			if (done) begin
				ledger.check_rounded('{out_sign, out_exponent, out_significand,
					inexact, bad_request});
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL float_round_to_prec_and_min_exp");
				$finish;
			end
		end
	end

	function round_req_t mk(logic s, int e, logic [63:0] c, logic hp, int p, logic hm,
			int m, logic nr, logic [1:0] d);
		round_req_t q;
		q.sgn = s;
		q.expo = e[15:0];
		q.sig = c;
		q.has_prec = hp;
		q.prec = p[PW-1:0];
		q.has_min = hm;
		q.min_pos = m[15:0];
		q.nearest = nr;
		q.dir = d;
		return q;
	endfunction

	function round_req_t random_request();
		round_req_t q;
		int kind, len, k, sel;
		logic [63:0] r;
		r = {$urandom, $urandom};
		kind = $urandom_range(0, 9);
		len = $urandom_range(0, 64);
		q.sgn = 1'($urandom);
		q.nearest = 1'($urandom);
		q.dir = 2'($urandom);
		if (kind <= 5)
			q.sig = (len == 0) ? '0 : (r >> (64 - len)) | (64'd1 << (len - 1));
		else if (kind <= 7)
			q.sig = (len == 0) ? '0 : ~64'd0 >> (64 - len);
		else
			q.sig = r;
		sel = $urandom_range(0, 9);
		if (sel < 8)
			q.expo = 16'($urandom_range(0, 400) - 200);
		else if (sel == 8)
			q.expo = 16'($urandom);
		else
			q.expo = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		q.prec = PW'(($urandom_range(0, 6) != 0) ? $urandom_range(1, 64)
			: $urandom_range(0, 127));
		q.min_pos = 16'(($urandom_range(0, 3) != 0) ? q.expo + $urandom_range(0, 72) - 4
			: $urandom);
		sel = $urandom_range(0, 19);
		q.has_prec = (sel >= 1 && sel <= 7) || sel >= 14;
		q.has_min = sel >= 8;
		if (kind == 9) begin
			// exact tie: half bit set, nothing below, cut right there
			k = $urandom_range(1, 63);
			q.sig = (r << k) | (64'd1 << (k - 1));
			q.has_prec = 1'b0;
			q.has_min = 1'b1;
			q.min_pos = 16'(q.expo + k - 1);
		end
		return q;
	endfunction

	// entered just after a rising edge; returns just after the transfer edge
	task send_item(round_req_t q);
		start <= 1'b1;
		sign <= q.sgn;
		exponent <= q.expo;
		significand <= q.sig;
		has_max_prec <= q.has_prec;
		max_prec <= q.prec;
		has_min_exp <= q.has_min;
		min_exp <= q.min_pos;
		round_nearest <= q.nearest;
		round_dir <= q.dir;
		do
			@(posedge clk);
		while (busy);
	endtask

	task pace(int idx);
		if (idx == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while (ledger.pending() != 0);
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 15);
		end
	endtask

	initial begin
		round_req_t corner[$];
		logic [63:0] ones;
		ones = ~64'd0;
		corner.push_back(mk(1, -5, 64'hdead, 0, 10, 0, -3, 1, fru_pkg::DIR_EVEN));
		corner.push_back(mk(0, 0, 0, 1, 8, 0, 0, 1, fru_pkg::DIR_EVEN));
		corner.push_back(mk(1, 100, 0, 0, 0, 1, -20, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 10, 64'h1234, 0, 0, 1, -100, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'hb, 1, 0, 0, 0, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, ones, 1, 127, 0, 0, 1, fru_pkg::DIR_ODD));
		corner.push_back(mk(1, 3, ones, 1, 64, 0, 0, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, ones, 1, 1, 0, 0, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'hb, 1, 3, 0, 0, 1, fru_pkg::DIR_EVEN));
		corner.push_back(mk(0, 0, 64'h9, 1, 3, 0, 0, 1, fru_pkg::DIR_ODD));
		corner.push_back(mk(1, 0, 64'hb, 1, 3, 0, 0, 1, fru_pkg::DIR_ZERO));
		corner.push_back(mk(0, 0, 64'h9, 1, 3, 0, 0, 1, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'h2e, 1, 3, 0, 0, 1, fru_pkg::DIR_ZERO));
		corner.push_back(mk(0, 0, 64'h2b, 1, 3, 0, 0, 1, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'hb5, 1, 4, 0, 0, 0, fru_pkg::DIR_ZERO));
		corner.push_back(mk(1, 0, 64'hb5, 1, 4, 0, 0, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'hb5, 1, 4, 0, 0, 0, fru_pkg::DIR_EVEN));
		corner.push_back(mk(1, 0, 64'hb5, 1, 4, 0, 0, 0, fru_pkg::DIR_ODD));
		corner.push_back(mk(0, 0, 64'hffff, 1, 40, 1, 5, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 0, 64'hffff, 1, 4, 1, -10, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(1, -32768, ones, 0, 0, 1, 32767, 0, fru_pkg::DIR_AWAY));
		corner.push_back(mk(0, 32767, 64'h8000_0000_0000_0001, 1, 2, 0, 0, 1,
			fru_pkg::DIR_EVEN));
		corner.push_back(mk(0, -32768, 64'h1, 0, 0, 1, -32768, 1, fru_pkg::DIR_ODD));
		corner.push_back(mk(1, -32768, 64'h5, 1, 64, 1, 32767, 1, fru_pkg::DIR_EVEN));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner[i]) begin
			send_item(corner[i]);
			pace(-1);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_item(random_request());
			pace(i);
		end
		start <= 1'b0;

		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("PASS float_round_to_prec_and_min_exp");
		else
			$display("FAIL float_round_to_prec_and_min_exp");
		$finish;
	end
endmodule
